FILE: design/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion converter.
package rmq_pkg;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } in_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } out_t;

  localparam int          SGN_BITS = 6;
  localparam int          SGN_21M12 = 0;
  localparam int          SGN_02M20 = 1;
  localparam int          SGN_10M01 = 2;
  localparam int          SGN_10P01 = 3;
  localparam int          SGN_02P20 = 4;
  localparam int          SGN_21P12 = 5;

  localparam logic [15:0] SAT_POS     = 16'h7FFF;
  localparam logic [15:0] SAT_NEG     = 16'h8000;
  localparam logic [16:0] SAT_POS_MAG = 17'd32767;
  localparam logic [16:0] SAT_NEG_MAG = 17'd32768;

endpackage

FILE: design/rmq_front.sv
// Front end: accept a matrix, form the clamped diagonal sums and the sign flags.
module rmq_front import rmq_pkg::*; #(
  parameter int FRAC_BITS = 14,
  parameter int UW        = 18
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_acc,
  input  in_t                         in_mat,
  output logic                        out_vld,
  output logic [4*UW+SGN_BITS-1:0]    out_item
);

  localparam int TW = UW + 1;
  localparam logic signed [TW-1:0] ONE =
    {{(TW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  logic signed [TW-1:0]       e00, e11, e22;
  logic signed [TW-1:0]       t0, t1, t2, t3;
  logic [UW-1:0]              u0, u1, u2, u3;
  logic signed [16:0]         d21m12, d02m20, d10m01, d10p01, d02p20, d21p12;
  logic [SGN_BITS-1:0]        sgn;
  logic                       vld_r;
  logic [4*UW+SGN_BITS-1:0]   item_r;

  always_comb begin
    e00 = TW'(in_mat.m00);
    e11 = TW'(in_mat.m11);
    e22 = TW'(in_mat.m22);
    t0  =  e00 + e11 + e22 + ONE;
    t1  =  e00 - e11 - e22 + ONE;
    t2  = -e00 + e11 - e22 + ONE;
    t3  = -e00 - e11 + e22 + ONE;
    u0  = t0[TW-1] ? '0 : t0[UW-1:0];
    u1  = t1[TW-1] ? '0 : t1[UW-1:0];
    u2  = t2[TW-1] ? '0 : t2[UW-1:0];
    u3  = t3[TW-1] ? '0 : t3[UW-1:0];
    d21m12 = 17'(in_mat.m21) - 17'(in_mat.m12);
    d02m20 = 17'(in_mat.m02) - 17'(in_mat.m20);
    d10m01 = 17'(in_mat.m10) - 17'(in_mat.m01);
    d10p01 = 17'(in_mat.m10) + 17'(in_mat.m01);
    d02p20 = 17'(in_mat.m02) + 17'(in_mat.m20);
    d21p12 = 17'(in_mat.m21) + 17'(in_mat.m12);
    sgn[SGN_21M12] = d21m12[16];
    sgn[SGN_02M20] = d02m20[16];
    sgn[SGN_10M01] = d10m01[16];
    sgn[SGN_10P01] = d10p01[16];
    sgn[SGN_02P20] = d02p20[16];
    sgn[SGN_21P12] = d21p12[16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= {u3, u2, u1, u0, sgn};
    end
  end

  assign out_vld  = vld_r;
  assign out_item = item_r;

endmodule

FILE: design/rmq_fifo.sv
// Two-entry queue between front end and back end.
module rmq_fifo #(
  parameter int W = 78
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_push,
  input  logic [W-1:0] in_data,
  output logic         out_full,
  output logic         out_vld,
  output logic [W-1:0] out_data
);

  logic [W-1:0] mem_r [2];
  logic         wp_r, wp_nxt;
  logic         rp_r, rp_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         pop;
  logic         vld_r;
  logic [W-1:0] dout_r;

  always_comb begin
    pop     = (cnt_r != 2'd0);
    wp_nxt  = in_push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(in_push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
      vld_r <= 1'b0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
      vld_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (in_push) begin
      mem_r[wp_r] <= in_data;
    end
    if (pop) begin
      dout_r <= mem_r[rp_r];
    end
  end

  assign out_full = (cnt_r == 2'd2);
  assign out_vld  = vld_r;
  assign out_data = dout_r;

endmodule

FILE: design/rmq_sqrt.sv
// Pipelined integer square root, one result bit per stage, several lanes.
module rmq_sqrt #(
  parameter int RW = 16,
  parameter int LN = 4,
  parameter int SW = 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  input  logic [LN-1:0][2*RW-1:0]      in_rad,
  input  logic [SW-1:0]                in_side,
  output logic                         out_vld,
  output logic [LN-1:0][RW-1:0]        out_root,
  output logic [SW-1:0]                out_side
);

  logic [LN-1:0][2*RW-1:0] rem_r  [RW];
  logic [LN-1:0][RW-1:0]   root_r [RW+1];
  logic [SW-1:0]           side_r [RW+1];
  logic                    vld_r  [RW+1];

  assign rem_r[0]  = in_rad;
  assign root_r[0] = '0;
  assign side_r[0] = in_side;
  assign vld_r[0]  = in_vld;

  for (genvar k = 0; k < RW; k++) begin : g_stg
    localparam int B = RW - 1 - k;
    logic [LN-1:0][2*RW-1:0] rem_nxt;
    logic [LN-1:0][RW-1:0]   root_nxt;

    always_comb begin
      logic [2*RW-1:0] trial;
      trial = '0;
      for (int l = 0; l < LN; l++) begin
        trial = ({{RW{1'b0}}, root_r[k][l]} << (B + 1)) | ((2*RW)'(1) << (2 * B));
        if (rem_r[k][l] >= trial) begin
          rem_nxt[l]  = rem_r[k][l] - trial;
          root_nxt[l] = root_r[k][l] | (RW'(1) << B);
        end else begin
          rem_nxt[l]  = rem_r[k][l];
          root_nxt[l] = root_r[k][l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      root_r[k+1] <= root_nxt;
      side_r[k+1] <= side_r[k];
    end

    if (k < RW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        rem_r[k+1] <= rem_nxt;
      end
    end
  end

  assign out_vld  = vld_r[RW];
  assign out_root = root_r[RW];
  assign out_side = side_r[RW];

endmodule

FILE: design/rmq_div.sv
// Pipelined restoring divider, one quotient bit per stage, shared divisor.
module rmq_div #(
  parameter int QW = 15,
  parameter int MW = 17,
  parameter int LN = 4,
  parameter int SW = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_vld,
  input  logic [LN-1:0][MW+QW-2:0]       in_num,
  input  logic [MW-1:0]                  in_den,
  input  logic [SW-1:0]                  in_side,
  output logic                           out_vld,
  output logic [LN-1:0][QW-1:0]          out_quo,
  output logic [SW-1:0]                  out_side
);

  localparam int DW = MW + QW - 1;

  logic [LN-1:0][DW-1:0] num_r  [QW];
  logic [MW-1:0]         den_r  [QW];
  logic [LN-1:0][QW-1:0] quo_r  [QW+1];
  logic [SW-1:0]         side_r [QW+1];
  logic                  vld_r  [QW+1];

  assign num_r[0]  = in_num;
  assign den_r[0]  = in_den;
  assign quo_r[0]  = '0;
  assign side_r[0] = in_side;
  assign vld_r[0]  = in_vld;

  for (genvar k = 0; k < QW; k++) begin : g_stg
    localparam int B = QW - 1 - k;
    logic [LN-1:0][DW-1:0] num_nxt;
    logic [LN-1:0][QW-1:0] quo_nxt;
    logic [DW-1:0]         sh;

    always_comb begin
      sh = DW'(den_r[k]) << B;
      for (int l = 0; l < LN; l++) begin
        if (num_r[k][l] >= sh) begin
          num_nxt[l] = num_r[k][l] - sh;
          quo_nxt[l] = quo_r[k][l] | (QW'(1) << B);
        end else begin
          num_nxt[l] = num_r[k][l];
          quo_nxt[l] = quo_r[k][l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      quo_r[k+1]  <= quo_nxt;
      side_r[k+1] <= side_r[k];
    end

    if (k < QW - 1) begin : g_num
      always_ff @(posedge clk) begin
        num_r[k+1] <= num_nxt;
        den_r[k+1] <= den_r[k];
      end
    end
  end

  assign out_vld  = vld_r[QW];
  assign out_quo  = quo_r[QW];
  assign out_side = side_r[QW];

endmodule

FILE: design/rmq_back.sv
// Back end: square roots, largest-component pick, magnitude, division, saturation.
module rmq_back import rmq_pkg::*; #(
  parameter int FRAC_BITS = 14,
  parameter int UW        = 18
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  logic [4*UW+SGN_BITS-1:0]    in_item,
  output logic                        out_vld,
  output out_t                        out_quat
);

  localparam int AW = (UW + FRAC_BITS + 1) / 2;
  localparam int MW = AW + 1;
  localparam int QW = FRAC_BITS + 1;
  localparam int DW = MW + QW - 1;
  localparam int QX = (QW > 17) ? QW : 17;

  logic [3:0][2*AW-1:0]    rad;
  logic                    sa_vld;
  logic [3:0][AW-1:0]      sa_root;
  logic [SGN_BITS-1:0]     sa_sgn;
  logic [1:0]              best;
  logic [3:0]              neg;

  logic                    s1_vld_r;
  logic [3:0][AW-1:0]      s1_a_r;
  logic [3:0][2*AW-1:0]    s1_sq_r;
  logic [3:0]              s1_neg_r;

  logic                    s2_vld_r;
  logic [3:0][AW-1:0]      s2_a_r;
  logic [2*AW:0]           s2_p0_r, s2_p1_r;
  logic [3:0]              s2_neg_r;

  logic                    s3_vld_r;
  logic [3:0][AW-1:0]      s3_a_r;
  logic [2*MW-1:0]         s3_mag2_r;
  logic [3:0]              s3_neg_r;

  logic                    sm_vld;
  logic [0:0][MW-1:0]      sm_root;
  logic [4*AW+3:0]         sm_side;
  logic [0:0][2*MW-1:0]    sm_rad;

  logic                    s4_vld_r;
  logic [3:0][DW-1:0]      s4_num_r;
  logic [MW-1:0]           s4_den_r;
  logic [3:0]              s4_neg_r;

  logic                    dv_vld;
  logic [3:0][QW-1:0]      dv_quo;
  logic [3:0]              dv_neg;

  logic [3:0][15:0]        sat;
  logic                    out_vld_r;
  out_t                    out_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rad[i] = (2*AW)'(in_item[SGN_BITS + i*UW +: UW]) << FRAC_BITS;
    end
  end

  rmq_sqrt #(.RW(AW), .LN(4), .SW(SGN_BITS)) u_sqrt_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_vld),
    .in_rad   (rad),
    .in_side  (in_item[SGN_BITS-1:0]),
    .out_vld  (sa_vld),
    .out_root (sa_root),
    .out_side (sa_sgn)
  );

  always_comb begin
    best = 2'd0;
    if (sa_root[1] > sa_root[best]) best = 2'd1;
    if (sa_root[2] > sa_root[best]) best = 2'd2;
    if (sa_root[3] > sa_root[best]) best = 2'd3;
    neg = 4'b0000;
    case (best)
      2'd0: begin
        neg[1] = sa_sgn[SGN_21M12];
        neg[2] = sa_sgn[SGN_02M20];
        neg[3] = sa_sgn[SGN_10M01];
      end
      2'd1: begin
        neg[0] = sa_sgn[SGN_21M12];
        neg[2] = sa_sgn[SGN_10P01];
        neg[3] = sa_sgn[SGN_02P20];
      end
      2'd2: begin
        neg[0] = sa_sgn[SGN_02M20];
        neg[1] = sa_sgn[SGN_10P01];
        neg[3] = sa_sgn[SGN_21P12];
      end
      default: begin
        neg[0] = sa_sgn[SGN_10M01];
        neg[1] = sa_sgn[SGN_02P20];
        neg[2] = sa_sgn[SGN_21P12];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= sa_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= sm_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      s1_sq_r[i] <= sa_root[i] * sa_root[i];
    end
    s1_a_r    <= sa_root;
    s1_neg_r  <= neg;
    s2_p0_r   <= (2*AW+1)'(s1_sq_r[0]) + (2*AW+1)'(s1_sq_r[1]);
    s2_p1_r   <= (2*AW+1)'(s1_sq_r[2]) + (2*AW+1)'(s1_sq_r[3]);
    s2_a_r    <= s1_a_r;
    s2_neg_r  <= s1_neg_r;
    s3_mag2_r <= (2*MW)'(s2_p0_r) + (2*MW)'(s2_p1_r);
    s3_a_r    <= s2_a_r;
    s3_neg_r  <= s2_neg_r;
  end

  assign sm_rad[0] = s3_mag2_r;

  rmq_sqrt #(.RW(MW), .LN(1), .SW(4*AW+4)) u_sqrt_m (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s3_vld_r),
    .in_rad   (sm_rad),
    .in_side  ({s3_a_r, s3_neg_r}),
    .out_vld  (sm_vld),
    .out_root (sm_root),
    .out_side (sm_side)
  );

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      s4_num_r[i] <= (DW'(sm_side[4 + i*AW +: AW]) << FRAC_BITS)
                   + DW'(sm_root[0] >> 1);
    end
    s4_den_r <= sm_root[0];
    s4_neg_r <= sm_side[3:0];
  end

  rmq_div #(.QW(QW), .MW(MW), .LN(4), .SW(4)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s4_vld_r),
    .in_num   (s4_num_r),
    .in_den   (s4_den_r),
    .in_side  (s4_neg_r),
    .out_vld  (dv_vld),
    .out_quo  (dv_quo),
    .out_side (dv_neg)
  );

  always_comb begin
    logic [QX-1:0] qx;
    qx = '0;
    for (int i = 0; i < 4; i++) begin
      qx = QX'(dv_quo[i]);
      if (dv_neg[i]) begin
        sat[i] = (qx > QX'(SAT_NEG_MAG)) ? SAT_NEG : (16'd0 - qx[15:0]);
      end else begin
        sat[i] = (qx > QX'(SAT_POS_MAG)) ? SAT_POS : qx[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_r.quat_w <= sat[0];
    out_r.quat_x <= sat[1];
    out_r.quat_y <= sat[2];
    out_r.quat_z <= sat[3];
  end

  assign out_vld  = out_vld_r;
  assign out_quat = out_r;

endmodule

FILE: design/rotation_matrix_to_quaternion.sv
// Top level of the rotation matrix to unit quaternion converter.
//
// Input: drive in_mat with nine signed Q(16-FRAC_BITS).FRAC_BITS matrix
// elements and raise start; the beat is taken at the rising edge where start
// is high and busy is low. busy rises only if the internal queue fills, which
// the free-running back end prevents, so a new beat may be offered every cycle.
// Output: out_valid is high for exactly one cycle per beat, with the unit
// quaternion (w, x, y, z) on out_quat; the receiver must take it then.
// Depth: AW = (FRAC_BITS + max(FRAC_BITS,16) + 3) / 2 is the per-component
// square root depth and MW = AW + 1 the magnitude square root depth. The two
// bit-serial square root pipelines and the FRAC_BITS + 1 stage divider set the
// depth from accept to out_valid.
// Throughput: one matrix per cycle; results leave in order of acceptance.
// Reset: synchronous, active low; clears all valid flags and the queue.
// In-flight beats are dropped.
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_mat,
  output logic out_valid,
  output out_t out_quat
);

  localparam int UW = ((FRAC_BITS > 16) ? FRAC_BITS : 16) + 2;
  localparam int IW = 4*UW + SGN_BITS;

  logic          acc;
  logic          fr_vld;
  logic [IW-1:0] fr_item;
  logic          q_full;
  logic          q_vld;
  logic [IW-1:0] q_item;

  assign acc  = start & ~q_full;
  assign busy = q_full;

  rmq_front #(.FRAC_BITS(FRAC_BITS), .UW(UW)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_acc   (acc),
    .in_mat   (in_mat),
    .out_vld  (fr_vld),
    .out_item (fr_item)
  );

  rmq_fifo #(.W(IW)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (fr_vld),
    .in_data  (fr_item),
    .out_full (q_full),
    .out_vld  (q_vld),
    .out_data (q_item)
  );

  rmq_back #(.FRAC_BITS(FRAC_BITS), .UW(UW)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (q_vld),
    .in_item  (q_item),
    .out_vld  (out_valid),
    .out_quat (out_quat)
  );

endmodule

FILE: verif/rotation_matrix_to_quaternion_tb.sv
// Testbench for the rotation matrix to quaternion converter: fixed-point predictor and scoreboard.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_tb;
  import rmq_pkg::*;

  localparam int FRAC = 14;
  localparam int LATENCY = 56;
  localparam longint LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_mat = '0;
  logic out_valid;
  out_t out_quat;

  in_t    pending_mats[$];
  out_t   expected_quats[$];
  int     gap_left = 0;
  bit     stim_done = 1'b0;
  bit     hold_for_drain = 1'b0;
  bit     drain_done = 1'b0;
  int     errors = 0;
  int     beats_in = 0;
  int     beats_out = 0;
  longint cycle = 0;

  rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC)) i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mat(in_mat), .out_valid(out_valid), .out_quat(out_quat)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic out_t quat_of(in_t m);
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22, one;
    longint t[4];
    longint unsigned root[4];
    longint unsigned mag2, mag, q;
    bit neg[4];
    int best;
    longint v[4];
    out_t r;
    a00 = m.m00; a01 = m.m01; a02 = m.m02;
    a10 = m.m10; a11 = m.m11; a12 = m.m12;
    a20 = m.m20; a21 = m.m21; a22 = m.m22;
    one = longint'(1) << FRAC;
    t[0] = a00 + a11 + a22 + one;
    t[1] = a00 - a11 - a22 + one;
    t[2] = -a00 + a11 - a22 + one;
    t[3] = -a00 - a11 + a22 + one;
    mag2 = 0;
    for (int i = 0; i < 4; i++) begin
      root[i] = int_sqrt((t[i] < 0 ? 64'd0 : longint'(t[i])) << FRAC);
      mag2 += root[i] * root[i];
      neg[i] = 1'b0;
    end
    best = 0;
    for (int i = 1; i < 4; i++) if (root[i] > root[best]) best = i;
    case (best)
      0: begin
        neg[1] = (a21 - a12) < 0; neg[2] = (a02 - a20) < 0; neg[3] = (a10 - a01) < 0;
      end
      1: begin
        neg[0] = (a21 - a12) < 0; neg[2] = (a10 + a01) < 0; neg[3] = (a02 + a20) < 0;
      end
      2: begin
        neg[0] = (a02 - a20) < 0; neg[1] = (a10 + a01) < 0; neg[3] = (a21 + a12) < 0;
      end
      default: begin
        neg[0] = (a10 - a01) < 0; neg[1] = (a20 + a02) < 0; neg[2] = (a21 + a12) < 0;
      end
    endcase
    mag = int_sqrt(mag2);
    if (mag == 0) begin
      r = '0;
      r.quat_w = clamp16(one);
      return r;
    end
    for (int i = 0; i < 4; i++) begin
      q = ((root[i] << FRAC) + (mag >> 1)) / mag;
      v[i] = neg[i] ? -longint'(q) : longint'(q);
    end
    r.quat_w = clamp16(v[0]);
    r.quat_x = clamp16(v[1]);
    r.quat_y = clamp16(v[2]);
    r.quat_z = clamp16(v[3]);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch at cycle %0d: %s got %h expected %h", cycle, what, got, want);
    errors++;
  endtask

  function automatic logic signed [15:0] rnd_elem();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      default: return 16'($urandom());
    endcase
  endfunction

  // Rotation about one random axis by a random angle, with -3 to +3 noise on each element.
  function automatic in_t rotation_mat();
    real ang, c, s;
    longint e[9];
    in_t m;
    ang = ($urandom_range(0, 62831) / 10000.0);
    c = $cos(ang) * 16384.0;
    s = $sin(ang) * 16384.0;
    case ($urandom_range(0, 2))
      0: e = '{16384, 0, 0, 0, longint'(c), -longint'(s), 0, longint'(s), longint'(c)};
      1: e = '{longint'(c), 0, longint'(s), 0, 16384, 0, -longint'(s), 0, longint'(c)};
      default: e = '{longint'(c), -longint'(s), 0, longint'(s), longint'(c), 0, 0, 0, 16384};
    endcase
    for (int i = 0; i < 9; i++) begin
      e[i] += longint'($urandom_range(0, 6)) - 3;
      if (e[i] > 32767) e[i] = 32767;
    end
    m = {e[0][15:0], e[1][15:0], e[2][15:0], e[3][15:0], e[4][15:0],
         e[5][15:0], e[6][15:0], e[7][15:0], e[8][15:0]};
    return m;
  endfunction

  initial begin
    in_t m;
    logic signed [15:0] one;
    one = 16'sd16384;
    m = '0; pending_mats.push_back(m);
    m = '1; pending_mats.push_back(m);
    m = {9{16'sh7FFF}}; pending_mats.push_back(m);
    m = {9{16'sh8000}}; pending_mats.push_back(m);
    // identity and half turns: each component wins in turn
    m = '0; m.m00 = one; m.m11 = one; m.m22 = one; pending_mats.push_back(m);
    m = '0; m.m00 = one; m.m11 = -one; m.m22 = -one; pending_mats.push_back(m);
    m = '0; m.m00 = -one; m.m11 = one; m.m22 = -one; pending_mats.push_back(m);
    m = '0; m.m00 = -one; m.m11 = -one; m.m22 = one; pending_mats.push_back(m);
    // ties between components, then one case that the y component wins alone
    m = '0; pending_mats.push_back(m);
    m = '0; m.m00 = one; pending_mats.push_back(m);
    m = '0; m.m11 = one; m.m22 = -one; pending_mats.push_back(m);
    // off-diagonal zero and negative sign cases
    m = '0; m.m00 = one; m.m11 = one; m.m22 = one; m.m21 = 16'sh8000; m.m12 = 16'sh7FFF;
    m.m02 = 16'sh8000; m.m20 = 16'sh7FFF; m.m10 = -16'sd5; m.m01 = 16'sd5;
    pending_mats.push_back(m);
    m = '0; m.m00 = one; m.m11 = -one; m.m22 = -one; m.m21 = -16'sd3; m.m12 = -16'sd3;
    m.m10 = -16'sd4; m.m01 = 16'sd1; m.m02 = -16'sd9; m.m20 = 16'sd2;
    pending_mats.push_back(m);
    m = '0; m.m00 = -one; m.m11 = -one; m.m22 = one; m.m10 = 16'sd7; m.m01 = -16'sd8;
    m.m20 = 16'sh8000; m.m02 = 16'sh8000; m.m21 = 16'sd3; m.m12 = -16'sd3;
    pending_mats.push_back(m);
    m = '0; m.m00 = 16'sh7FFF; m.m11 = 16'sh7FFF; m.m22 = 16'sh7FFF; pending_mats.push_back(m);
    m = '0; m.m00 = 16'sh7FFF; m.m11 = 16'sh8000; m.m22 = 16'sh8000; pending_mats.push_back(m);
    for (int i = 0; i < 1100; i++) begin
      if ($urandom_range(0, 3) != 0) begin
        m = rotation_mat();
      end else begin
        m = {rnd_elem(), rnd_elem(), rnd_elem(), rnd_elem(), rnd_elem(),
             rnd_elem(), rnd_elem(), rnd_elem(), rnd_elem()};
      end
      pending_mats.push_back(m);
    end
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle == 10) rst_n <= 1'b1;
    if (cycle >= LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        expected_quats.push_back(quat_of(in_mat));
        beats_in <= beats_in + 1;
      end
      if (start && busy) begin
        // hold the beat
      end else if (hold_for_drain) begin
        start <= 1'b0;
        if (expected_quats.size() == 0 && !(start && !busy)) hold_for_drain <= 1'b0;
      end else if (!drain_done && beats_in >= 600) begin
        start <= 1'b0;
        hold_for_drain <= 1'b1;
        drain_done <= 1'b1;
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_mats.size() > 0) begin
        in_mat <= pending_mats.pop_front();
        start <= 1'b1;
        gap_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : 0;
      end else begin
        start <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid) begin
      beats_out <= beats_out + 1;
      if (expected_quats.size() == 0) begin
        $display("unexpected beat at cycle %0d", cycle);
        errors++;
      end else begin
        want = expected_quats.pop_front();
        if (out_quat.quat_w !== want.quat_w) report_mismatch("quat_w", out_quat.quat_w, want.quat_w);
        if (out_quat.quat_x !== want.quat_x) report_mismatch("quat_x", out_quat.quat_x, want.quat_x);
        if (out_quat.quat_y !== want.quat_y) report_mismatch("quat_y", out_quat.quat_y, want.quat_y);
        if (out_quat.quat_z !== want.quat_z) report_mismatch("quat_z", out_quat.quat_z, want.quat_z);
      end
    end
  end

  initial begin
    while (!(stim_done && expected_quats.size() == 0)) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    $display("Converted %0d matrices (rotations, extremes, random patterns), %0d checked.",
             beats_in, beats_out);
    if (errors == 0 && expected_quats.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: rotation_matrix_to_quaternion.f
design/rmq_pkg.sv
design/rmq_front.sv
design/rmq_fifo.sv
design/rmq_sqrt.sv
design/rmq_div.sv
design/rmq_back.sv
design/rotation_matrix_to_quaternion.sv
verif/rotation_matrix_to_quaternion_tb.sv
